// File: rtl/core/gaze_position_velocity_filter_assert.svh
// assertion macros for the gaze filter
// used by the gaze filter controller
`ifndef GAZE_POSITION_VELOCITY_FILTER_ASSERT_SVH
`define GAZE_POSITION_VELOCITY_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define GPVF_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error("gpvf check failed");
`define GPVF_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error("gpvf forbidden");
`else
`define GPVF_ASSERT(label, prop)
`define GPVF_ASSERT_NEVER(label, cond)
`endif
`endif

// File: rtl/core/gpvf_pkg.sv
// shared types and constants for the gaze filter
// no dependencies
package gpvf_pkg;
	localparam int MAX_WINDOW_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int VAL_W = 48;
	localparam int SUM_W = 56;
	localparam int VEL_SCALE = 500;
	localparam logic [15:0] MISSING_RAW = 16'h8000;

	localparam logic [2:0] REG_X_OFFSET = 3'd0;
	localparam logic [2:0] REG_Y_OFFSET = 3'd1;
	localparam logic [2:0] REG_X_GAIN = 3'd2;
	localparam logic [2:0] REG_Y_GAIN = 3'd3;
	localparam logic [2:0] REG_SMOOTH = 3'd4;
	localparam logic [2:0] REG_EYES = 3'd5;

	localparam logic [1:0] EYES_LEFT = 2'd0;
	localparam logic [1:0] EYES_RIGHT = 2'd1;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture input item
		logic div_start; // start divider on current channel
		logic pos_step;  // store position of current channel
		logic vel_step;  // update velocity and start average divide
		logic avg_done;  // store averaged velocity
		logic [1:0] chan; // eye*2+axis
		logic finish;    // advance slots, present result
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic chan_rec;  // channel's eye recorded
		logic chan_got;  // channel's eye has both coordinates
	} sts_t;
endpackage

// File: rtl/core/gaze_position_velocity_filter.sv
// gaze position and velocity filter, top level
// depends on gpvf_pkg, gpvf_ctrl, gpvf_dp and, through gpvf_ctrl, the assertion header
//
// Usage: one tracker sample enters on the s_axis channel; one result leaves
// on m_axis. Configuration goes through the APB port (registers at 4*i).
// Each sample is worked channel by channel (left x, left y, right x, right y)
// through one shared 56-bit restoring divider: a velocity average divide per
// recorded channel, preceded by a position divide when that eye has both
// coordinates. One sample is processed at a time; the next sample is taken in
// the cycle its predecessor's result transfers. While the receiver stalls the
// result holds and no new sample is taken. Reset clears histories, sums,
// time origin and error, and sets registers to their defaults.
module gaze_position_velocity_filter #(
	parameter int MAX_WINDOW = gpvf_pkg::MAX_WINDOW_DEF,
	parameter int FRAC_BITS = gpvf_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// start_req, sample_time, left_raw_x, left_raw_y, right_raw_x, right_raw_y
	input  logic [103:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status, relative_time, left_present, right_present, left_pos_x/y,
	// right_pos_x/y, left_vel_x/y, right_vel_x/y
	output logic [423:0] m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	gpvf_pkg::cmd_t cmd;
	gpvf_pkg::sts_t sts;
	logic [418:0] res;
	logic cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	gpvf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .cmd(cmd), .sts(sts)
	);

	gpvf_dp #(.MAX_WINDOW(MAX_WINDOW), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .in_data(s_axis_tdata[96:0]),
		.cfg_we(cfg_we), .cfg_idx(paddr[4:2]), .cfg_wdata(pwdata[15:0]),
		.cfg_rdata(prdata), .res_data(res)
	);

	assign m_axis_tdata = {5'h0, res};
endmodule

// File: rtl/core/gpvf_div.sv
// iterative signed divider, one quotient bit per cycle, truncating
// no dependencies
module gpvf_div #(
	parameter int W = 56
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] num,
	input  logic signed [W-1:0] den,
	output logic                busy,
	output logic signed [W-1:0] quo
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] rem_q, quo_q, den_q;
	logic [W:0] trial;
	logic [CW-1:0] cnt_q;
	logic neg_q;
	logic [W-1:0] rem_sh;

	assign rem_sh = {rem_q[W-2:0], quo_q[W-1]};
	assign trial = {1'b0, rem_sh} - {1'b0, den_q};
	assign busy = (cnt_q != '0);
	assign quo = neg_q ? -$signed(quo_q) : $signed(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num[W-1] ? -num : num;
			den_q <= den[W-1] ? -den : den;
			neg_q <= num[W-1] ^ den[W-1];
		end else if (busy) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end
endmodule

// File: rtl/core/gpvf_dp.sv
// datapath: registers, histories, velocity sums, shared divider
// depends on gpvf_pkg and gpvf_div
module gpvf_dp #(
	parameter int MAX_WINDOW = gpvf_pkg::MAX_WINDOW_DEF,
	parameter int FRAC_BITS = gpvf_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gpvf_pkg::cmd_t      cmd,
	output gpvf_pkg::sts_t      sts,
	input  logic [96:0]         in_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [15:0]         cfg_wdata,
	output logic [31:0]         cfg_rdata,
	output logic [418:0]        res_data
);
	localparam int VW = gpvf_pkg::VAL_W;
	localparam int SW = gpvf_pkg::SUM_W;
	localparam int WW = $clog2(MAX_WINDOW + 1);
	localparam int IW = $clog2(MAX_WINDOW);
	localparam int WIN_RST = (MAX_WINDOW < 8) ? MAX_WINDOW : 8;
	localparam logic signed [VW-1:0] MAXV = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] MINV = {1'b1, {(VW-1){1'b0}}};

	logic [15:0] xo_q, yo_q, xg_q, yg_q;
	logic [5:0] sw_q;
	logic [1:0] em_q;
	logic [31:0] origin_q, last_q, rel_q;
	logic err_q;
	logic [15:0] raw_q [4];
	logic signed [VW-1:0] ph_q [3][4];
	logic signed [VW-1:0] vh_q [MAX_WINDOW*4];
	logic [MAX_WINDOW*4-1:0] vvld_q;
	logic signed [SW-1:0] vs_q [4];
	logic [1:0] pslot_q;
	logic [WW-1:0] vslot_q, win_q, old_v;
	logic signed [VW-1:0] pos_q [4], vel_q [4];
	logic pres_q [2];
	logic signed [VW-1:0] vold_q;

	logic [WW-1:0] wclamp;
	logic [1:0] old_p, t0, prev_p;
	logic [1:0] ch;
	logic [IW+1:0] vidx;
	logic ax, eye;
	logic rec [2];
	logic got [2];
	logic signed [SW-1:0] dnum, dden, dquo;
	logic signed [16:0] diff;
	logic signed [15:0] gain;
	logic signed [VW+9:0] vraw;
	logic signed [VW-1:0] vsat;
	logic signed [SW-1:0] nsum;
	logic dbusy, dstart;

	assign ch = cmd.chan;
	assign ax = ch[0];
	assign eye = ch[1];
	assign rec[0] = em_q != gpvf_pkg::EYES_RIGHT;
	assign rec[1] = em_q != gpvf_pkg::EYES_LEFT;
	assign got[0] = raw_q[0] != gpvf_pkg::MISSING_RAW && raw_q[1] != gpvf_pkg::MISSING_RAW;
	assign got[1] = raw_q[2] != gpvf_pkg::MISSING_RAW && raw_q[3] != gpvf_pkg::MISSING_RAW;
	assign sts.div_busy = dbusy;
	assign sts.chan_rec = rec[eye];
	assign sts.chan_got = got[eye];

	always_comb begin
		if (sw_q == '0) wclamp = WW'(1);
		else if (32'(sw_q) > 32'(MAX_WINDOW)) wclamp = WW'(MAX_WINDOW);
		else wclamp = WW'(sw_q);
	end

	assign old_p = (pslot_q == 2'd3) ? 2'd0 : pslot_q;
	assign t0 = (old_p == 2'd0) ? 2'd2 : old_p - 2'd1;
	assign prev_p = (old_p == 2'd2) ? 2'd0 : old_p + 2'd1;
	assign old_v = (vslot_q >= win_q) ? win_q - 1'b1 : vslot_q;
	assign vidx = {old_v[IW-1:0], ch};

	assign diff = $signed({raw_q[ch][15], raw_q[ch]}) -
		$signed(ax ? {yo_q[15], yo_q} : {xo_q[15], xo_q});
	assign gain = ax ? $signed(yg_q) : $signed(xg_q);

	// position divide or velocity average share the divider
	always_comb begin
		if (cmd.vel_step) begin
			dnum = nsum;
			dden = SW'(win_q);
		end else begin
			dnum = SW'(diff) <<< FRAC_BITS;
			dden = (gain == '0) ? SW'(1) : SW'(gain);
		end
	end
	assign dstart = cmd.div_start | cmd.vel_step;

	gpvf_div #(.W(SW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.busy(dbusy), .quo(dquo)
	);

	assign vraw = ((VW+10)'(pos_q[ch]) - (VW+10)'(ph_q[t0][ch])) * (VW+10)'(gpvf_pkg::VEL_SCALE);
	assign vsat = (vraw > (VW+10)'(MAXV)) ? MAXV :
		(vraw < (VW+10)'(MINV)) ? MINV : vraw[VW-1:0];
	assign nsum = vs_q[ch] + SW'(vsat) - SW'(vold_q);

	always_comb begin
		case (cfg_idx)
			gpvf_pkg::REG_X_OFFSET: cfg_rdata = {16'h0, xo_q};
			gpvf_pkg::REG_Y_OFFSET: cfg_rdata = {16'h0, yo_q};
			gpvf_pkg::REG_X_GAIN: cfg_rdata = {16'h0, xg_q};
			gpvf_pkg::REG_Y_GAIN: cfg_rdata = {16'h0, yg_q};
			gpvf_pkg::REG_SMOOTH: cfg_rdata = {26'h0, sw_q};
			gpvf_pkg::REG_EYES: cfg_rdata = {30'h0, em_q};
			default: cfg_rdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xo_q <= '0; yo_q <= '0; xg_q <= 16'd1; yg_q <= 16'd1;
			sw_q <= 6'd8; em_q <= 2'd2;
		end else if (cfg_we) begin
			case (cfg_idx)
				gpvf_pkg::REG_X_OFFSET: xo_q <= cfg_wdata;
				gpvf_pkg::REG_Y_OFFSET: yo_q <= cfg_wdata;
				gpvf_pkg::REG_X_GAIN: xg_q <= cfg_wdata;
				gpvf_pkg::REG_Y_GAIN: yg_q <= cfg_wdata;
				gpvf_pkg::REG_SMOOTH: sw_q <= cfg_wdata[5:0];
				gpvf_pkg::REG_EYES: em_q <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// velocity history is a memory: one read, one write per step
	// entries not written since start read as zero
	always_ff @(posedge clk) begin
		if (cmd.pos_step) vold_q <= vvld_q[vidx] ? vh_q[vidx] : '0;
		if (cmd.vel_step) vh_q[vidx] <= vsat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) for (int j = 0; j < 4; j++) ph_q[i][j] <= '0;
			for (int j = 0; j < 4; j++) begin
				vs_q[j] <= '0; pos_q[j] <= '0; vel_q[j] <= '0; raw_q[j] <= '0;
			end
			vvld_q <= '0;
			pslot_q <= 2'd2; win_q <= WW'(WIN_RST); vslot_q <= WW'(WIN_RST - 1);
			origin_q <= '0; last_q <= '0; err_q <= 1'b0; rel_q <= '0;
			pres_q[0] <= 1'b0; pres_q[1] <= 1'b0;
		end else begin
			if (cmd.load) begin
				for (int j = 0; j < 4; j++) raw_q[j] <= in_data[33+16*j +: 16];
				if (in_data[0]) begin
					for (int i = 0; i < 3; i++) for (int j = 0; j < 4; j++) ph_q[i][j] <= '0;
					for (int j = 0; j < 4; j++) vs_q[j] <= '0;
					vvld_q <= '0;
					pslot_q <= 2'd2; win_q <= wclamp; vslot_q <= wclamp - 1'b1;
					origin_q <= in_data[32:1]; last_q <= '0; err_q <= 1'b0;
					rel_q <= '0;
				end else begin
					rel_q <= in_data[32:1] - origin_q;
					if (last_q + 32'd1 != in_data[32:1] - origin_q) err_q <= 1'b1;
					last_q <= in_data[32:1] - origin_q;
				end
				for (int j = 0; j < 4; j++) begin
					pos_q[j] <= '0; vel_q[j] <= '0;
				end
				pres_q[0] <= 1'b0; pres_q[1] <= 1'b0;
			end
			if (cmd.pos_step) begin
				pos_q[ch] <= got[eye] ? dquo[VW-1:0] : ph_q[prev_p][ch];
				ph_q[old_p][ch] <= got[eye] ? dquo[VW-1:0] : ph_q[prev_p][ch];
				pres_q[eye] <= got[eye];
			end
			if (cmd.vel_step) begin
				vs_q[ch] <= nsum;
				vvld_q[vidx] <= 1'b1;
			end
			if (cmd.avg_done) vel_q[ch] <= dquo[VW-1:0];
			if (cmd.finish) begin
				pslot_q <= t0;
				vslot_q <= (old_v == '0) ? win_q - 1'b1 : old_v - 1'b1;
			end
		end
	end

	// result packed from the lowest bit: status, relative_time, presence,
	// positions, velocities
	assign res_data = {
		vel_q[3], vel_q[2], vel_q[1], vel_q[0],
		pos_q[3], pos_q[2], pos_q[1], pos_q[0],
		pres_q[1], pres_q[0], rel_q, err_q};
endmodule

// File: rtl/core/gpvf_ctrl.sv
// controller: sequences four channels through the shared divider
// depends on gpvf_pkg and the assertion header
`include "gaze_position_velocity_filter_assert.svh"
module gpvf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output gpvf_pkg::cmd_t cmd,
	input  gpvf_pkg::sts_t sts
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_POSDIV = 7'b0000010,
		S_POSWAIT = 7'b0000100,
		S_VEL = 7'b0001000,
		S_VELWAIT = 7'b0010000,
		S_NEXT = 7'b0100000,
		S_OUT = 7'b1000000
	} state_t;

	state_t state_q;
	logic [1:0] chan_q;
	logic launch;

	assign in_ready = (state_q == S_IDLE) || (state_q == S_OUT && out_ready);
	assign out_valid = (state_q == S_OUT);
	assign launch = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.chan = chan_q;
		cmd.load = launch;
		case (state_q)
			S_POSDIV: cmd.div_start = sts.chan_rec && sts.chan_got;
			S_POSWAIT: cmd.pos_step = !sts.div_busy;
			S_VEL: cmd.vel_step = 1'b1;
			S_VELWAIT: cmd.avg_done = !sts.div_busy;
			S_NEXT: cmd.finish = (chan_q == 2'd3);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chan_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (launch) begin
					state_q <= S_POSDIV; chan_q <= '0;
				end
				S_POSDIV: state_q <= sts.chan_rec ? S_POSWAIT : S_NEXT;
				S_POSWAIT: if (!sts.div_busy) state_q <= S_VEL;
				S_VEL: state_q <= S_VELWAIT;
				S_VELWAIT: if (!sts.div_busy) state_q <= S_NEXT;
				S_NEXT: begin
					chan_q <= chan_q + 2'd1;
					state_q <= (chan_q == 2'd3) ? S_OUT : S_POSDIV;
				end
				S_OUT: if (launch) begin
					state_q <= S_POSDIV; chan_q <= '0;
				end else if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`GPVF_ASSERT(a_onehot, $onehot(state_q))
	`GPVF_ASSERT_NEVER(a_load_busy, cmd.load && state_q != S_IDLE && state_q != S_OUT)
	`GPVF_ASSERT(a_vel_then_wait, cmd.vel_step |=> state_q == S_VELWAIT)
endmodule
